/* hdl/lcdc_pkg.sv */
// Package for the character LCD controller: beat types, operation codes,
// register indexes, command bytes and reset values. No dependencies.
`default_nettype none

package lcdc_pkg;

  localparam int unsigned LCDC_ROW_CHARS = 16;
  localparam int unsigned LCDC_WAIT_W    = 16;

  localparam logic [LCDC_WAIT_W-1:0] LCDC_POWER_ON_WAIT_RST = 16'd1311;
  localparam logic [LCDC_WAIT_W-1:0] LCDC_LONG_WAIT_RST     = 16'd66;
  localparam logic [LCDC_WAIT_W-1:0] LCDC_SHORT_WAIT_RST    = 16'd2;

  localparam logic [7:0] LCDC_CMD_WAKE    = 8'h03;
  localparam logic [7:0] LCDC_CMD_FUNC    = 8'h38;
  localparam logic [7:0] LCDC_CMD_ENTRY   = 8'h06;
  localparam logic [7:0] LCDC_CMD_DISPLAY = 8'h0C;
  localparam logic [7:0] LCDC_CMD_CLEAR   = 8'h01;
  localparam logic [7:0] LCDC_CMD_HOME    = 8'h02;
  localparam logic [7:0] LCDC_CMD_LINE2   = 8'hC0;
  localparam logic [7:0] LCDC_CHAR_SPACE  = 8'h20;
  localparam logic [7:0] LCDC_CHAR_NUL    = 8'h00;

  localparam logic [1:0] LCDC_WAKE_PULSES = 2'd3;

  typedef enum logic [2:0] {
    OP_NONE   = 3'd0,
    OP_INIT   = 3'd1,
    OP_ERASE  = 3'd2,
    OP_UPDATE = 3'd3,
    OP_WRITE  = 3'd4
  } lcdc_op_e;

  typedef enum logic [1:0] {
    ST_NONE     = 2'd0,
    ST_ACCEPTED = 2'd1,
    ST_REFUSED  = 2'd2
  } lcdc_status_e;

  typedef enum logic [1:0] {
    CFG_POWER_ON_WAIT = 2'd0,
    CFG_LONG_WAIT     = 2'd1,
    CFG_SHORT_WAIT    = 2'd2
  } lcdc_cfg_e;

  typedef struct packed {
    logic [2:0] operation;
    logic       tick;
    logic [4:0] text_index;
    logic [7:0] text_byte;
  } lcdc_item_t;

  typedef struct packed {
    logic       bus_write;
    logic       reg_select;
    logic [7:0] bus_data;
    logic       busy_res;
    logic [1:0] request_status;
  } lcdc_result_t;

  typedef struct packed {
    logic wr_en;
    logic clear;
    logic snapshot;
  } lcdc_store_ctl_t;

endpackage

`default_nettype wire

/* hdl/lcdc_text_store.sv */
// Shadow and working text held in two banks with a bank pointer per entry.
// Depends on lcdc_pkg for the store control struct and the space code.
`default_nettype none

module lcdc_text_store
  import lcdc_pkg::*;
#(
  parameter int unsigned ROW_CHARS = LCDC_ROW_CHARS,
  localparam int unsigned TEXT_LEN = 2 * ROW_CHARS,
  localparam int unsigned AW = $clog2(TEXT_LEN)
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire lcdc_store_ctl_t ctl_i,
  input  wire logic [AW-1:0]   wr_addr_i,
  input  wire logic [7:0]      wr_data_i,
  input  wire logic [AW-1:0]   rd_addr_i,
  output logic [7:0]           rd_char_o
);

  // The shadow copy of an entry lives in the bank named by cur_q, the
  // working copy in the bank named by snap_q. A write that would hit the
  // working copy goes to the other bank instead.
  logic [7:0]          bank0_q [TEXT_LEN];
  logic [7:0]          bank1_q [TEXT_LEN];
  logic [TEXT_LEN-1:0] vld0_q;
  logic [TEXT_LEN-1:0] vld1_q;
  logic [TEXT_LEN-1:0] cur_q;
  logic [TEXT_LEN-1:0] snap_q;
  logic                wr_bank;

  assign wr_bank = (cur_q[wr_addr_i] == snap_q[wr_addr_i]) ? ~cur_q[wr_addr_i]
                                                           : cur_q[wr_addr_i];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld0_q <= '0;
      vld1_q <= '0;
      cur_q  <= '0;
      snap_q <= '0;
    end else begin
      if (ctl_i.clear) begin
        vld0_q <= '0;
        vld1_q <= '0;
      end else if (ctl_i.wr_en) begin
        cur_q[wr_addr_i] <= wr_bank;
        if (wr_bank) begin
          vld1_q[wr_addr_i] <= 1'b1;
        end else begin
          vld0_q[wr_addr_i] <= 1'b1;
        end
      end
      if (ctl_i.snapshot) begin
        snap_q <= cur_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.wr_en) begin
      if (wr_bank) begin
        bank1_q[wr_addr_i] <= wr_data_i;
      end else begin
        bank0_q[wr_addr_i] <= wr_data_i;
      end
    end
  end

  always_comb begin
    if (snap_q[rd_addr_i]) begin
      rd_char_o = vld1_q[rd_addr_i] ? bank1_q[rd_addr_i] : LCDC_CHAR_SPACE;
    end else begin
      rd_char_o = vld0_q[rd_addr_i] ? bank0_q[rd_addr_i] : LCDC_CHAR_SPACE;
    end
  end

endmodule

`default_nettype wire

/* hdl/lcdc_seq.sv */
// Command sequencer: tick wait, request handling and at most one sequence step per
// item. Depends on lcdc_pkg; drives the text store's control and read port.
`default_nettype none

module lcdc_seq
  import lcdc_pkg::*;
#(
  parameter int unsigned ROW_CHARS = LCDC_ROW_CHARS,
  localparam int unsigned TEXT_LEN = 2 * ROW_CHARS,
  localparam int unsigned AW = $clog2(TEXT_LEN),
  localparam int unsigned CW = $clog2(ROW_CHARS + 1)
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   step_i,
  input  wire lcdc_item_t             item_i,
  input  wire logic [LCDC_WAIT_W-1:0] power_on_wait_i,
  input  wire logic [LCDC_WAIT_W-1:0] long_wait_i,
  input  wire logic [LCDC_WAIT_W-1:0] short_wait_i,
  output logic [AW-1:0]               rd_addr_o,
  input  wire logic [7:0]             rd_char_i,
  output lcdc_store_ctl_t             store_ctl_o,
  output lcdc_result_t                result_o
);

  typedef enum logic [3:0] {
    SEQ_IDLE,
    INIT_POWER,
    INIT_PULSE,
    INIT_FUNC,
    INIT_ENTRY,
    INIT_DISPLAY,
    INIT_CLEAR,
    INIT_DONE,
    ERASE_CLEAR,
    ERASE_DONE,
    UPD_HOME,
    UPD_LINE1,
    UPD_NEXT,
    UPD_LINE2,
    UPD_DONE
  } seq_state_e;

  seq_state_e             state_q, state_d, cur;
  logic                   wait_q, wait_d;
  logic [LCDC_WAIT_W-1:0] rem_q, rem_d;
  logic [CW-1:0]          ci_q, ci_d;
  logic [1:0]             pulse_q, pulse_d;
  logic                   blank_q, blank_d;

  logic                   emit, emit_rs, start, blank_n;
  logic [7:0]             emit_data;
  logic [LCDC_WAIT_W-1:0] ticks;
  lcdc_store_ctl_t        ctl;
  lcdc_result_t           res;

  assign rd_addr_o = (state_q == UPD_LINE2) ? AW'(ROW_CHARS) + AW'(ci_q) : AW'(ci_q);
  assign blank_n   = blank_q | (rd_char_i == LCDC_CHAR_NUL);

  always_comb begin
    state_d   = state_q;
    wait_d    = wait_q;
    rem_d     = rem_q;
    ci_d      = ci_q;
    pulse_d   = pulse_q;
    blank_d   = blank_q;
    emit      = 1'b0;
    emit_rs   = 1'b0;
    emit_data = '0;
    start     = 1'b0;
    ticks     = short_wait_i;
    ctl       = '0;
    res       = '0;
    cur       = SEQ_IDLE;

    if (item_i.tick && wait_q) begin
      if (rem_q != '0) begin
        rem_d = rem_q - LCDC_WAIT_W'(1);
      end
      if (rem_d == '0) begin
        wait_d = 1'b0;
      end
    end

    case (lcdc_op_e'(item_i.operation))
      OP_INIT, OP_ERASE, OP_UPDATE: begin
        if (state_q != SEQ_IDLE) begin
          res.request_status = ST_REFUSED;
        end else begin
          res.request_status = ST_ACCEPTED;
          case (lcdc_op_e'(item_i.operation))
            OP_INIT:  state_d = INIT_POWER;
            OP_ERASE: state_d = ERASE_CLEAR;
            default: begin
              state_d      = UPD_HOME;
              ctl.snapshot = 1'b1;
            end
          endcase
        end
      end
      OP_WRITE: begin
        if (32'(item_i.text_index) < 32'(TEXT_LEN)) begin
          ctl.wr_en = 1'b1;
        end
      end
      default: ;
    endcase

    if (state_d != SEQ_IDLE && !wait_d) begin
      cur = state_d;
      case (cur)
        INIT_POWER: begin
          ctl.clear = 1'b1;
          start     = 1'b1;
          ticks     = power_on_wait_i;
          pulse_d   = '0;
          state_d   = INIT_PULSE;
        end
        INIT_PULSE: begin
          emit      = 1'b1;
          emit_data = LCDC_CMD_WAKE;
          ticks     = long_wait_i;
          pulse_d   = pulse_q + 2'd1;
          if (pulse_q == LCDC_WAKE_PULSES - 2'd1) begin
            pulse_d = '0;
            state_d = INIT_FUNC;
          end
        end
        INIT_FUNC: begin
          emit      = 1'b1;
          emit_data = LCDC_CMD_FUNC;
          state_d   = INIT_ENTRY;
        end
        INIT_ENTRY: begin
          emit      = 1'b1;
          emit_data = LCDC_CMD_ENTRY;
          state_d   = INIT_DISPLAY;
        end
        INIT_DISPLAY: begin
          emit      = 1'b1;
          emit_data = LCDC_CMD_DISPLAY;
          state_d   = INIT_CLEAR;
        end
        INIT_CLEAR, ERASE_CLEAR: begin
          emit      = 1'b1;
          emit_data = LCDC_CMD_CLEAR;
          ticks     = long_wait_i;
          state_d   = (cur == INIT_CLEAR) ? INIT_DONE : ERASE_DONE;
        end
        ERASE_DONE: begin
          ctl.clear = 1'b1;
          state_d   = SEQ_IDLE;
        end
        UPD_HOME: begin
          emit      = 1'b1;
          emit_data = LCDC_CMD_HOME;
          ticks     = long_wait_i;
          ci_d      = '0;
          blank_d   = 1'b0;
          state_d   = UPD_LINE1;
        end
        UPD_NEXT: begin
          emit      = 1'b1;
          emit_data = LCDC_CMD_LINE2;
          ci_d      = '0;
          blank_d   = 1'b0;
          state_d   = UPD_LINE2;
        end
        UPD_LINE1, UPD_LINE2: begin
          emit      = 1'b1;
          emit_rs   = 1'b1;
          blank_d   = blank_n;
          emit_data = blank_n ? LCDC_CHAR_SPACE : rd_char_i;
          ci_d      = ci_q + CW'(1);
          if (ci_d == CW'(ROW_CHARS)) begin
            state_d = (cur == UPD_LINE1) ? UPD_NEXT : UPD_DONE;
          end
        end
        default: begin
          state_d = SEQ_IDLE;
        end
      endcase
    end

    if (emit) begin
      start          = 1'b1;
      res.bus_write  = 1'b1;
      res.reg_select = emit_rs;
      res.bus_data   = emit_data;
    end
    if (start) begin
      wait_d = 1'b1;
      rem_d  = (ticks == '0) ? LCDC_WAIT_W'(1) : ticks;
    end
    res.busy_res = (state_d != SEQ_IDLE);
  end

  assign store_ctl_o = step_i ? ctl : '0;
  assign result_o    = res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SEQ_IDLE;
      wait_q  <= 1'b0;
      rem_q   <= '0;
      ci_q    <= '0;
      pulse_q <= '0;
      blank_q <= 1'b0;
    end else if (step_i) begin
      state_q <= state_d;
      wait_q  <= wait_d;
      rem_q   <= rem_d;
      ci_q    <= ci_d;
      pulse_q <= pulse_d;
      blank_q <= blank_d;
    end
  end

endmodule

`default_nettype wire

/* hdl/lcd_character_controller.sv */
// Top level of the character LCD controller: input and result registers,
// wait registers and the instances of lcdc_seq and lcdc_text_store.
// Depends on lcdc_pkg.
//
//   port group      direction  flow control     beat
//   in_*            in         valid / stall    lcdc_item_t
//   out_*           out        valid / stall    lcdc_result_t
//   cfg_*           in         valid / ready    register index and 16-bit value
//
// One beat is taken per cycle while the input is not stalled; its result is registered through
// the input register and then the result register, around one step of the sequencer.
// After reset the wait registers hold their defaults and the text reads as spaces.
// A stalled output holds its beat; input stall follows once both registers are full.
// Configuration writes are always ready.
`default_nettype none

module lcd_character_controller
  import lcdc_pkg::*;
#(
  parameter int unsigned ROW_CHARS = LCDC_ROW_CHARS
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   in_valid_i,
  output logic                        in_stall_o,
  input  wire lcdc_item_t             in_data_i,
  output logic                        out_valid_o,
  input  wire logic                   out_stall_i,
  output lcdc_result_t                out_data_o,
  input  wire logic                   cfg_valid_i,
  output logic                        cfg_ready_o,
  input  wire logic [1:0]             cfg_index_i,
  input  wire logic [LCDC_WAIT_W-1:0] cfg_data_i
);

  localparam int unsigned AW = $clog2(2 * ROW_CHARS);

  lcdc_item_t             item_q;
  logic                   in_vld_q;
  lcdc_result_t           res_q;
  logic                   out_vld_q;
  logic [LCDC_WAIT_W-1:0] power_on_wait_q, long_wait_q, short_wait_q;

  logic                   out_free, advance;
  lcdc_result_t           res;
  lcdc_store_ctl_t        store_ctl;
  logic [AW-1:0]          rd_addr;
  logic [7:0]             rd_char;

  assign out_free    = !out_vld_q || !out_stall_i;
  assign advance     = in_vld_q && out_free;
  assign in_stall_o  = in_vld_q && !out_free;
  assign out_valid_o = out_vld_q;
  assign out_data_o  = res_q;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q        <= 1'b0;
      out_vld_q       <= 1'b0;
      power_on_wait_q <= LCDC_POWER_ON_WAIT_RST;
      long_wait_q     <= LCDC_LONG_WAIT_RST;
      short_wait_q    <= LCDC_SHORT_WAIT_RST;
    end else begin
      if (!in_stall_o) begin
        in_vld_q <= in_valid_i;
      end
      if (out_free) begin
        out_vld_q <= in_vld_q;
      end
      if (cfg_valid_i && cfg_ready_o) begin
        case (lcdc_cfg_e'(cfg_index_i))
          CFG_POWER_ON_WAIT: power_on_wait_q <= cfg_data_i;
          CFG_LONG_WAIT:     long_wait_q     <= cfg_data_i;
          CFG_SHORT_WAIT:    short_wait_q    <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      item_q <= in_data_i;
    end
    if (advance) begin
      res_q <= res;
    end
  end

  lcdc_seq #(
    .ROW_CHARS(ROW_CHARS)
  ) u_seq (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .step_i         (advance),
    .item_i         (item_q),
    .power_on_wait_i(power_on_wait_q),
    .long_wait_i    (long_wait_q),
    .short_wait_i   (short_wait_q),
    .rd_addr_o      (rd_addr),
    .rd_char_i      (rd_char),
    .store_ctl_o    (store_ctl),
    .result_o       (res)
  );

  lcdc_text_store #(
    .ROW_CHARS(ROW_CHARS)
  ) u_store (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctl_i    (store_ctl),
    .wr_addr_i(AW'(item_q.text_index)),
    .wr_data_i(item_q.text_byte),
    .rd_addr_i(rd_addr),
    .rd_char_o(rd_char)
  );

endmodule

`default_nettype wire

/* hdl/lcdc_checker.sv */
// Port-level checks for the character LCD controller, bound to the top level.
// Depends on lcdc_pkg for the beat types and status codes.
`default_nettype none

module lcdc_checker
  import lcdc_pkg::*;
(
  input wire logic                   clk_i,
  input wire logic                   rst_ni,
  input wire logic                   in_stall_o,
  input wire logic                   out_valid_o,
  input wire logic                   out_stall_i,
  input wire lcdc_result_t           out_data_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("result beat changed while stalled");

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without a stalled result");

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.request_status == ST_ACCEPTED |-> out_data_o.busy_res)
    else $error("accepted request reported idle");

  a_write_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.bus_write |-> out_data_o.busy_res)
    else $error("bus write while idle");

  a_quiet_bus: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.bus_write |->
      !out_data_o.reg_select && out_data_o.bus_data == '0)
    else $error("bus driven without a write");

endmodule

bind lcd_character_controller lcdc_checker u_lcdc_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_stall_o (in_stall_o),
  .out_valid_o(out_valid_o),
  .out_stall_i(out_stall_i),
  .out_data_o (out_data_o)
);

`default_nettype wire

/* tb/tb_top.sv */
// Self-checking testbench for lcd_character_controller: a scoreboard class predicts every
// result beat of the LCD command sequencer and checks it, while plain tasks drive the block.
// Depends on lcdc_pkg and the RTL of lcd_character_controller.
`timescale 1ns / 1ps

module tb_top;
  import lcdc_pkg::*;

  localparam int TEXT_LEN = 2 * LCDC_ROW_CHARS;
  localparam logic [2:0] OP_SPARE_LO = 3'd5;
  localparam logic [2:0] OP_SPARE_HI = 3'd7;
  localparam logic [1:0] CFG_SPARE_IDX = 2'd3;

  class lcd_bus_tracker_t;
    logic [15:0]  power_wait, long_wait, short_wait;
    logic [3:0]   seq_step;
    lcdc_op_e     cur_order;
    logic         in_prog, waiting, blanked;
    logic [15:0]  wait_left;
    logic [5:0]   char_idx;
    logic [1:0]   pulses;
    logic [7:0]   shadow [TEXT_LEN];
    logic [7:0]   working [TEXT_LEN];
    lcdc_result_t beat;
    lcdc_result_t beats_due [$];
    int           errors;

    function new();
      power_wait = LCDC_POWER_ON_WAIT_RST;
      long_wait  = LCDC_LONG_WAIT_RST;
      short_wait = LCDC_SHORT_WAIT_RST;
      seq_step   = '0;
      cur_order  = OP_NONE;
      in_prog    = 1'b0;
      waiting    = 1'b0;
      blanked    = 1'b0;
      wait_left  = '0;
      char_idx   = '0;
      pulses     = '0;
      errors     = 0;
      blank_text();
      foreach (working[i]) working[i] = '0;
    endfunction

    function void blank_text();
      foreach (shadow[i]) shadow[i] = LCDC_CHAR_SPACE;
    endfunction

    function void set_reg(logic [1:0] idx, logic [15:0] val);
      case (idx)
        CFG_POWER_ON_WAIT: power_wait = val;
        CFG_LONG_WAIT:     long_wait = val;
        CFG_SHORT_WAIT:    short_wait = val;
        default: ;
      endcase
    endfunction

    function void start_hold(logic [15:0] ticks);
      waiting   = 1'b1;
      wait_left = (ticks == 16'd0) ? 16'd1 : ticks;
    endfunction

    function void emit(logic rs, logic [7:0] data, logic [15:0] ticks);
      beat.bus_write  = 1'b1;
      beat.reg_select = rs;
      beat.bus_data   = data;
      start_hold(ticks);
    endfunction

    function void finish_op();
      in_prog  = 1'b0;
      seq_step = '0;
    endfunction

    function void send_char(int base, logic [3:0] next);
      logic [7:0] c;
      c = working[base + char_idx];
      if (c == LCDC_CHAR_NUL) blanked = 1'b1;
      if (blanked) c = LCDC_CHAR_SPACE;
      emit(1'b1, c, short_wait);
      char_idx++;
      if (char_idx >= LCDC_ROW_CHARS) seq_step = next;
    endfunction

    function void run_step();
      case (cur_order)
        OP_INIT: begin
          case (seq_step)
            4'd0: begin
              blank_text();
              start_hold(power_wait);
              pulses   = '0;
              seq_step = 4'd1;
            end
            4'd1: begin
              emit(1'b0, LCDC_CMD_WAKE, long_wait);
              pulses++;
              if (pulses >= LCDC_WAKE_PULSES) begin
                pulses   = '0;
                seq_step = 4'd2;
              end
            end
            4'd2: begin emit(1'b0, LCDC_CMD_FUNC, short_wait); seq_step = 4'd3; end
            4'd3: begin emit(1'b0, LCDC_CMD_ENTRY, short_wait); seq_step = 4'd4; end
            4'd4: begin emit(1'b0, LCDC_CMD_DISPLAY, short_wait); seq_step = 4'd5; end
            4'd5: begin emit(1'b0, LCDC_CMD_CLEAR, long_wait); seq_step = 4'd6; end
            default: finish_op();
          endcase
        end
        OP_ERASE: begin
          if (seq_step == 4'd0) begin
            emit(1'b0, LCDC_CMD_CLEAR, long_wait);
            seq_step = 4'd1;
          end else begin
            blank_text();
            finish_op();
          end
        end
        OP_UPDATE: begin
          case (seq_step)
            4'd0: begin
              emit(1'b0, LCDC_CMD_HOME, long_wait);
              char_idx = '0;
              blanked  = 1'b0;
              seq_step = 4'd1;
            end
            4'd1: send_char(0, 4'd2);
            4'd2: begin
              emit(1'b0, LCDC_CMD_LINE2, short_wait);
              char_idx = '0;
              blanked  = 1'b0;
              seq_step = 4'd3;
            end
            4'd3: send_char(LCDC_ROW_CHARS, 4'd4);
            default: finish_op();
          endcase
        end
        default: finish_op();
      endcase
    endfunction

    function void take_item(lcdc_item_t it);
      lcdc_status_e status;
      beat   = '0;
      status = ST_NONE;
      if (it.tick && waiting) begin
        if (wait_left != 16'd0) wait_left--;
        if (wait_left == 16'd0) waiting = 1'b0;
      end
      case (it.operation)
        OP_INIT, OP_ERASE, OP_UPDATE: begin
          if (in_prog) begin
            status = ST_REFUSED;
          end else begin
            status    = ST_ACCEPTED;
            cur_order = lcdc_op_e'(it.operation);
            in_prog   = 1'b1;
            seq_step  = '0;
            if (it.operation == OP_UPDATE) working = shadow;
          end
        end
        OP_WRITE: shadow[it.text_index] = it.text_byte;
        default: ;
      endcase
      if (in_prog && !waiting) run_step();
      beat.busy_res       = in_prog;
      beat.request_status = status;
      beats_due.push_back(beat);
    endfunction

    function void match_field(string field, logic [7:0] want, logic [7:0] got);
      if (got !== want) begin
        errors++;
        $display("%0t: %s expected %0h, got %0h", $time, field, want, got);
      end
    endfunction

    function void check_beat(lcdc_result_t got);
      lcdc_result_t want;
      if (beats_due.size() == 0) begin
        errors++;
        $display("%0t: result beat %h arrived with nothing expected", $time, got);
        return;
      end
      want = beats_due.pop_front();
      match_field("bus_write", want.bus_write, got.bus_write);
      match_field("reg_select", want.reg_select, got.reg_select);
      match_field("bus_data", want.bus_data, got.bus_data);
      match_field("busy_res", want.busy_res, got.busy_res);
      match_field("request_status", want.request_status, got.request_status);
    endfunction
  endclass

  logic         clk_i;
  logic         rst_ni;
  logic         in_valid_i;
  logic         in_stall_o;
  lcdc_item_t   in_data_i;
  logic         out_valid_o;
  logic         out_stall_i;
  lcdc_result_t out_data_o;
  logic         cfg_valid_i;
  logic         cfg_ready_o;
  logic [1:0]   cfg_index_i;
  logic [15:0]  cfg_data_i;

  lcd_bus_tracker_t bus;
  bit gaps_on;
  bit stall_on;
  int hold_request;
  int tick_pct;
  bit init_ok;

  lcd_character_controller dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #20ms;
    $display("tb_top: FAIL");
    $finish;
  end

  function automatic lcdc_item_t item_of(logic [2:0] op, logic tick, logic [4:0] idx,
                                         logic [7:0] data);
    lcdc_item_t it;
    it.operation  = op;
    it.tick       = tick;
    it.text_index = idx;
    it.text_byte  = data;
    return it;
  endfunction

  function automatic logic [2:0] pick_request();
    int r;
    r = $urandom_range(9);
    if (r < 6) return OP_UPDATE;
    if (r < 8 || (!init_ok && !bus.in_prog)) return OP_ERASE;
    return OP_INIT;
  endfunction

  function automatic lcdc_item_t make_item();
    lcdc_item_t it;
    int roll;
    roll          = $urandom_range(99);
    it.tick       = ($urandom_range(99) < tick_pct);
    it.text_index = 5'($urandom_range(TEXT_LEN - 1));
    it.text_byte  = ($urandom_range(7) == 0) ? LCDC_CHAR_NUL : 8'($urandom_range(255));
    if (roll < 4) it.operation = 3'($urandom_range(OP_SPARE_LO, OP_SPARE_HI));
    else if (roll < 10) it.operation = pick_request();
    else if (!bus.in_prog && roll < 55) it.operation = pick_request();
    else if (roll < 75) it.operation = OP_WRITE;
    else it.operation = OP_NONE;
    return it;
  endfunction

  // Entered and left at a falling edge; valid stays high after the beat is taken.
  task automatic push_item(input lcdc_item_t it);
    while (gaps_on && $urandom_range(99) < 36) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= it;
    do @(posedge clk_i); while (in_stall_o);
    bus.take_item(it);
    @(negedge clk_i);
  endtask

  task automatic run_items(input int count);
    repeat (count) push_item(make_item());
    in_valid_i <= 1'b0;
  endtask

  task automatic wait_for_results();
    while (bus.beats_due.size() != 0) @(negedge clk_i);
  endtask

  task automatic set_mode(input bit gaps, input bit stalls, input int hold);
    @(posedge clk_i);
    gaps_on      = gaps;
    stall_on     = stalls;
    hold_request = hold;
    @(negedge clk_i);
  endtask

  task automatic cfg_beat(input logic [1:0] idx, input logic [15:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    bus.set_reg(idx, val);
    @(negedge clk_i);
  endtask

  task automatic load_waits(input logic [15:0] pw, input logic [15:0] lw,
                            input logic [15:0] sw, input bit spare);
    wait_for_results();
    repeat (3) @(negedge clk_i);
    cfg_beat(CFG_POWER_ON_WAIT, pw);
    cfg_beat(CFG_LONG_WAIT, lw);
    cfg_beat(CFG_SHORT_WAIT, sw);
    if (spare) cfg_beat(CFG_SPARE_IDX, 16'($urandom));
    cfg_valid_i <= 1'b0;
  endtask

  task automatic run_directed();
    push_item(item_of(OP_NONE, 1'b0, 5'd0, 8'h00));
    push_item(item_of(OP_NONE, 1'b1, 5'd31, 8'hFF));
    for (int op = OP_SPARE_LO; op <= OP_SPARE_HI; op++)
      push_item(item_of(3'(op), 1'b1, 5'(op), 8'hA5));
    push_item(item_of(OP_WRITE, 1'b0, 5'd0, 8'hFF));
    push_item(item_of(OP_WRITE, 1'b1, 5'd5, LCDC_CHAR_NUL));
    push_item(item_of(OP_WRITE, 1'b0, 5'd15, 8'h41));
    push_item(item_of(OP_WRITE, 1'b0, 5'd16, 8'h7E));
    push_item(item_of(OP_WRITE, 1'b0, 5'd20, LCDC_CHAR_NUL));
    push_item(item_of(OP_WRITE, 1'b0, 5'd30, 8'h80));
    push_item(item_of(OP_WRITE, 1'b0, 5'd31, 8'h01));
    push_item(item_of(OP_UPDATE, 1'b0, 5'd0, 8'h00));
    push_item(item_of(OP_ERASE, 1'b1, 5'd0, 8'h00));
    push_item(item_of(OP_INIT, 1'b0, 5'd0, 8'h00));
    push_item(item_of(OP_UPDATE, 1'b1, 5'd0, 8'h00));
    push_item(item_of(OP_WRITE, 1'b1, 5'd1, 8'h55));
    push_item(item_of(OP_SPARE_HI, 1'b1, 5'd2, 8'h00));
    push_item(item_of(OP_NONE, 1'b1, 5'd0, 8'h00));
    push_item(item_of(OP_WRITE, 1'b0, 5'd31, LCDC_CHAR_NUL));
    in_valid_i <= 1'b0;
  endtask

  initial begin : receiver
    int hold_left;
    hold_left   = 0;
    out_stall_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_request != 0) begin
        hold_left    = hold_request;
        hold_request = 0;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= stall_on && ($urandom_range(99) < 36);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) bus.check_beat(out_data_o);
  end

  initial begin : stimulus
    bus          = new();
    rst_ni       = 1'b0;
    in_valid_i   = 1'b0;
    in_data_i    = '0;
    cfg_valid_i  = 1'b0;
    cfg_index_i  = '0;
    cfg_data_i   = '0;
    gaps_on      = 1'b1;
    stall_on     = 1'b1;
    hold_request = 0;
    tick_pct     = 95;
    init_ok      = 1'b0;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Reset values of the wait registers; no init is started while they hold.
    run_directed();
    run_items(40);

    // Shortest waits with both sides running flat out.
    load_waits(16'd1, 16'd1, 16'd1, 1'b0);
    set_mode(1'b0, 1'b0, 0);
    init_ok  = 1'b1;
    tick_pct = 60;
    run_items(100);

    // Zero waits count as one tick; the receiver holds off at first, so the input stalls.
    load_waits(16'd0, 16'd0, 16'd0, 1'b1);
    set_mode(1'b1, 1'b1, 200);
    tick_pct = 50;
    run_items(80);

    // A long power-on wait, run to the end.
    while (bus.in_prog) push_item(item_of(OP_NONE, 1'b1, 5'd0, 8'h00));
    in_valid_i <= 1'b0;
    load_waits(16'd40, 16'd3, 16'd2, 1'b0);
    set_mode(1'b1, 1'b1, 0);
    init_ok  = 1'b0;
    tick_pct = 97;
    push_item(item_of(OP_INIT, 1'b0, 5'd0, 8'h00));
    run_items(70);

    load_waits(16'd9, 16'd4, 16'd3, 1'b0);
    set_mode(1'b1, 1'b1, 300);
    init_ok  = 1'b1;
    tick_pct = 70;
    run_items(50);
    wait_for_results();
    run_items(50);

    wait_for_results();
    repeat (6) @(negedge clk_i);
    if (bus.errors == 0 && bus.beats_due.size() == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule

/* lcd_character_controller.f */
hdl/lcdc_pkg.sv
hdl/lcdc_text_store.sv
hdl/lcdc_seq.sv
hdl/lcd_character_controller.sv
hdl/lcdc_checker.sv
tb/tb_top.sv
